@@ hw/rtl/ealc_pkg.sv @@
// ealc_pkg: shared types and fixed constants of the encoder angle correction unit
// no dependencies; imported by every module of the block

package ealc_pkg;

  // geometry: revolution, table and bin sizes are powers of two
  localparam int unsigned CountsPerRev = 16384;
  localparam int unsigned TableSize    = 128;
  localparam int unsigned BinCounts    = 128;

  localparam int unsigned CountW = $clog2(CountsPerRev);
  localparam int unsigned IdxW   = $clog2(TableSize);
  localparam int unsigned FracW  = $clog2(BinCounts);
  localparam int unsigned OffW   = 16;
  // (o1 - o0) is OffW+1 bits, the fraction gets a sign bit
  localparam int unsigned ProdW  = OffW + 1 + FracW + 1;

  localparam int unsigned DropW    = 4;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 4;

  typedef enum logic [CfgIdxW-1:0] {
    CfgCorrEnable = 1'b0,
    CfgDropBits   = 1'b1
  } ealc_cfg_idx_e;

  typedef enum logic {
    ModeSample = 1'b0,
    ModeWrite  = 1'b1
  } ealc_mode_e;

  typedef struct packed {
    logic                   en;
    logic [IdxW-1:0]        addr;
    logic signed [OffW-1:0] data;
  } ealc_wr_req_t;

  typedef struct packed {
    logic            en;
    logic [IdxW-1:0] addr;
  } ealc_rd_req_t;

endpackage

@@ hw/rtl/encoder_lut_angle_correction_unit.sv @@
// encoder_lut_angle_correction_unit: top level of the encoder angle correction unit
// depends on ealc_pkg, ealc_table and ealc_interp

// The unit takes one word per clock cycle and, when the output is not held
// back, keeps that rate indefinitely. A write word (mode 1) stores a signed
// offset into the 128-entry table in the cycle it is accepted and gives no
// result. A sample word (mode 0) gives exactly one corrected count: the edge
// that accepts it registers the paired table read, the interpolation stage
// then registers the slope multiply, and the output register takes the final
// subtract, wrap and low-bit drop. Up to three samples are in flight; ready
// drops only while all three stages are full and the output word is not being
// taken. The table has no reset, so every entry that a sample can touch (the
// bin of the count and the one after it, wrapping at the table end) must be
// written before correction is enabled. Configuration must be written only
// while idle; the unit itself does not enforce this.

module encoder_lut_angle_correction_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // input words
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               mode_i,
  input  logic [ealc_pkg::CountW-1:0]        raw_count_i,
  input  logic [ealc_pkg::IdxW-1:0]          entry_index_i,
  input  logic signed [ealc_pkg::OffW-1:0]   entry_offset_i,
  // result words
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [ealc_pkg::CountW-1:0]        corrected_count_o,
  // configuration writes
  input  logic                               cfg_we_i,
  input  logic [ealc_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [ealc_pkg::CfgDataW-1:0]      cfg_wdata_i
);
  import ealc_pkg::*;

  // configuration registers
  logic             corr_en_q, corr_en_d;
  logic [DropW-1:0] drop_bits_q, drop_bits_d;

  // pipeline occupancy
  logic s1_v_q, s1_v_d;
  logic s2_v_q, s2_v_d;
  logic out_v_q, out_v_d;

  // stage one payload: count alongside the registered table pair
  logic [CountW-1:0] s1_count_q;

  logic signed [OffW-1:0]  tab_o0, tab_o1;
  logic signed [ProdW-1:0] s2_prod;
  logic signed [OffW-1:0]  s2_o0;
  logic [CountW-1:0]       s2_count;

  logic [CountW-1:0] result_q, result_d;

  logic in_acc, sample_acc;
  logic s1_free, s2_free, s2_load, out_load;

  ealc_wr_req_t wr_req;
  ealc_rd_req_t rd_req;

  logic signed [ProdW-1:0] prod_adj;
  logic signed [ProdW-1:0] quot;
  logic [CountW-1:0]       corr_count;
  logic [CountW-1:0]       keep_mask;

  // stage moves: a stage takes the word behind it when it is empty or emptying
  assign out_load = s2_v_q & (~out_v_q | out_ready_i);
  assign s2_free  = ~s2_v_q | out_load;
  assign s2_load  = s1_v_q & s2_free;
  assign s1_free  = ~s1_v_q | s2_load;

  assign in_ready_o = s1_free;
  assign in_acc     = in_valid_i & in_ready_o;
  assign sample_acc = in_acc & (mode_i == ModeSample);

  // table access; the entry index field spans the whole table
  assign wr_req.en   = in_acc & (mode_i == ModeWrite);
  assign wr_req.addr = entry_index_i;
  assign wr_req.data = entry_offset_i;

  // the count range equals one revolution, so the wrap is the field itself
  assign rd_req.en   = sample_acc;
  assign rd_req.addr = raw_count_i[CountW-1:FracW];

  ealc_table u_table (
    .clk_i (clk_i),
    .wr_i  (wr_req),
    .rd_i  (rd_req),
    .o0_o  (tab_o0),
    .o1_o  (tab_o1)
  );

  always_ff @(posedge clk_i) begin
    if (sample_acc) begin
      s1_count_q <= raw_count_i;
    end
  end

  ealc_interp u_interp (
    .clk_i   (clk_i),
    .en_i    (s2_load),
    .o0_i    (tab_o0),
    .o1_i    (tab_o1),
    .count_i (s1_count_q),
    .prod_o  (s2_prod),
    .o0_o    (s2_o0),
    .count_o (s2_count)
  );

  // divide by the bin size truncating toward zero: bias negatives by bin-1
  assign prod_adj = s2_prod + {{(ProdW-FracW){1'b0}}, {FracW{s2_prod[ProdW-1]}}};
  assign quot     = prod_adj >>> FracW;

  // count - (o0 + quot), wrapped to one revolution by keeping the low bits
  assign corr_count = s2_count - s2_o0[CountW-1:0] - quot[CountW-1:0];

  // drop settings past the count width clear the whole word
  assign keep_mask = {CountW{1'b1}} << drop_bits_q;

  assign result_d = (corr_en_q ? corr_count : s2_count) & keep_mask;

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      result_q <= result_d;
    end
  end

  // valid flags
  always_comb begin
    s1_v_d  = sample_acc ? 1'b1 : (s2_load ? 1'b0 : s1_v_q);
    s2_v_d  = s2_load ? 1'b1 : (out_load ? 1'b0 : s2_v_q);
    out_v_d = out_load ? 1'b1 : ((out_v_q & out_ready_i) ? 1'b0 : out_v_q);
  end

  // configuration decode
  always_comb begin
    corr_en_d   = corr_en_q;
    drop_bits_d = drop_bits_q;
    if (cfg_we_i) begin
      case (ealc_cfg_idx_e'(cfg_index_i))
        CfgCorrEnable: corr_en_d   = cfg_wdata_i[0];
        CfgDropBits:   drop_bits_d = cfg_wdata_i[DropW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q      <= 1'b0;
      s2_v_q      <= 1'b0;
      out_v_q     <= 1'b0;
      corr_en_q   <= 1'b0;
      drop_bits_q <= '0;
    end else begin
      s1_v_q      <= s1_v_d;
      s2_v_q      <= s2_v_d;
      out_v_q     <= out_v_d;
      corr_en_q   <= corr_en_d;
      drop_bits_q <= drop_bits_d;
    end
  end

  assign out_valid_o       = out_v_q;
  assign corrected_count_o = result_q;

endmodule

@@ hw/rtl/ealc_table.sv @@
// ealc_table: offset table memory, one write port and a registered pair read
// depends on ealc_pkg

module ealc_table (
  input  logic                            clk_i,
  input  ealc_pkg::ealc_wr_req_t          wr_i,
  input  ealc_pkg::ealc_rd_req_t          rd_i,
  output logic signed [ealc_pkg::OffW-1:0] o0_o,
  output logic signed [ealc_pkg::OffW-1:0] o1_o
);
  import ealc_pkg::*;

  logic signed [OffW-1:0] mem_q [TableSize];
  logic signed [OffW-1:0] o0_q;
  logic signed [OffW-1:0] o1_q;
  logic [IdxW-1:0]        next_addr;

  // next entry wraps at the table end
  assign next_addr = IdxW'(rd_i.addr + 1'b1);

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      o0_q <= mem_q[rd_i.addr];
      o1_q <= mem_q[next_addr];
    end
  end

  assign o0_o = o0_q;
  assign o1_o = o1_q;

endmodule

@@ hw/rtl/ealc_interp.sv @@
// ealc_interp: registered slope times fraction stage of the interpolation
// depends on ealc_pkg

module ealc_interp (
  input  logic                             clk_i,
  input  logic                             en_i,
  input  logic signed [ealc_pkg::OffW-1:0] o0_i,
  input  logic signed [ealc_pkg::OffW-1:0] o1_i,
  input  logic [ealc_pkg::CountW-1:0]      count_i,
  output logic signed [ealc_pkg::ProdW-1:0] prod_o,
  output logic signed [ealc_pkg::OffW-1:0] o0_o,
  output logic [ealc_pkg::CountW-1:0]      count_o
);
  import ealc_pkg::*;

  logic signed [OffW:0]    diff;
  logic signed [FracW:0]   frac_s;
  logic signed [ProdW-1:0] prod_d;
  logic signed [ProdW-1:0] prod_q;
  logic signed [OffW-1:0]  o0_q;
  logic [CountW-1:0]       count_q;

  assign diff   = {o1_i[OffW-1], o1_i} - {o0_i[OffW-1], o0_i};
  assign frac_s = {1'b0, count_i[FracW-1:0]};
  assign prod_d = diff * frac_s;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q  <= prod_d;
      o0_q    <= o0_i;
      count_q <= count_i;
    end
  end

  assign prod_o  = prod_q;
  assign o0_o    = o0_q;
  assign count_o = count_q;

endmodule

@@ hw/rtl/ealc_checker.sv @@
// ealc_checker: port-level checks of the encoder angle correction unit
// depends on ealc_pkg; bound to encoder_lut_angle_correction_unit below

module ealc_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_ready_o,
  input logic                             mode_i,
  input logic                             out_valid_o,
  input logic                             out_ready_i,
  input logic [ealc_pkg::CountW-1:0]      corrected_count_o
);
  import ealc_pkg::*;

  // samples accepted but not yet delivered
  logic [1:0] occ_q, occ_d;
  logic       smp_in, word_out;

  assign smp_in   = in_valid_i & in_ready_o & (mode_i == ModeSample);
  assign word_out = out_valid_o & out_ready_i;

  always_comb begin
    occ_d = occ_q;
    if (smp_in & ~word_out) begin
      occ_d = 2'(occ_q + 2'd1);
    end else if (~smp_in & word_out) begin
      occ_d = 2'(occ_q - 2'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else begin
      occ_q <= occ_d;
    end
  end

  // a stalled result word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(corrected_count_o))
    else $error("result word changed while stalled");

  // input only blocks while the output is held back
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output back-pressure");

  // no result word without a sample in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> occ_q != 2'd0)
    else $error("result word with no sample outstanding");

  // three stages hold at most three samples: no acceptance when full and stuck
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q == 2'd3 && !word_out |-> !smp_in)
    else $error("sample accepted beyond pipeline depth");

endmodule

bind encoder_lut_angle_correction_unit ealc_checker u_ealc_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_ready_o        (in_ready_o),
  .mode_i            (mode_i),
  .out_valid_o       (out_valid_o),
  .out_ready_i       (out_ready_i),
  .corrected_count_o (corrected_count_o)
);
